>>> design/odo_pkg.sv
// ----------------------------------------------------------------------------
// odo_pkg
// Shared types, register map, datapath commands and constants of the
// differential-drive odometry unit.
// ----------------------------------------------------------------------------
package odo_pkg;

    // Register indexes on the configuration port (byte address = 4 * index)
    localparam logic [1:0] REG_DIST_PER_PULSE  = 2'd0;
    localparam logic [1:0] REG_ANGLE_PER_PULSE = 2'd1;
    localparam logic [1:0] REG_DISTANCE_SCALE  = 2'd2;

    localparam logic [23:0] DIST_PER_PULSE_RST  = 24'd171294;
    localparam logic [23:0] ANGLE_PER_PULSE_RST = 24'd184207;
    localparam logic [17:0] DISTANCE_SCALE_RST  = 18'd87381;

    // CORDIC start vector, Q1.30 gain compensation
    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    typedef struct packed {
        logic [23:0] dist_per_pulse;
        logic [23:0] angle_per_pulse;
        logic [17:0] distance_scale;
    } cfg_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_HEAD,
        OP_SUM,
        OP_INIT,
        OP_ROT,
        OP_FIX,
        OP_MXL,
        OP_MXH,
        OP_MYL,
        OP_MYH,
        OP_SQX,
        OP_SQY,
        OP_SQY2,
        OP_SQI,
        OP_ROOT,
        OP_SCALE,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t        op;
        logic [4:0] idx;
    } cmd_t;

    typedef struct packed {
        logic out_busy;
    } status_t;

    // Arctangent of 2^-i in 2^-32 turn units
    function automatic logic signed [33:0] atan_turn(input logic [4:0] i);
        logic signed [33:0] v;
        begin
            case (i)
                5'd0:    v = 34'sd536870912;
                5'd1:    v = 34'sd316933406;
                5'd2:    v = 34'sd167458907;
                5'd3:    v = 34'sd85004756;
                5'd4:    v = 34'sd42667331;
                5'd5:    v = 34'sd21354465;
                5'd6:    v = 34'sd10679838;
                5'd7:    v = 34'sd5340245;
                5'd8:    v = 34'sd2670163;
                5'd9:    v = 34'sd1335087;
                5'd10:   v = 34'sd667544;
                5'd11:   v = 34'sd333772;
                5'd12:   v = 34'sd166886;
                5'd13:   v = 34'sd83443;
                5'd14:   v = 34'sd41722;
                5'd15:   v = 34'sd20861;
                5'd16:   v = 34'sd10430;
                5'd17:   v = 34'sd5215;
                5'd18:   v = 34'sd2608;
                5'd19:   v = 34'sd1304;
                5'd20:   v = 34'sd652;
                5'd21:   v = 34'sd326;
                5'd22:   v = 34'sd163;
                5'd23:   v = 34'sd81;
                5'd24:   v = 34'sd41;
                5'd25:   v = 34'sd20;
                5'd26:   v = 34'sd10;
                5'd27:   v = 34'sd5;
                5'd28:   v = 34'sd3;
                5'd29:   v = 34'sd1;
                5'd30:   v = 34'sd1;
                default: v = 34'sd0;
            endcase
            return v;
        end
    endfunction

    // Clamp a 37-bit signed sum to the signed 32-bit range
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        begin
            if (v > 37'sd2147483647)
                r = 32'sh7FFFFFFF;
            else if (v < -37'sd2147483648)
                r = 32'sh80000000;
            else
                r = v[31:0];
            return r;
        end
    endfunction

endpackage

>>> design/odo_sample_if.sv
// ----------------------------------------------------------------------------
// odo_sample_if
// Input channel: wheel encoder pulse counts of one sample period.
// ----------------------------------------------------------------------------
interface odo_sample_if;
    logic        valid;
    logic        ready;
    logic [15:0] pulses_left;
    logic [15:0] pulses_right;

    modport source (output valid, output pulses_left, output pulses_right, input ready);
    modport sink   (input valid, input pulses_left, input pulses_right, output ready);
endinterface

>>> design/odo_result_if.sv
// ----------------------------------------------------------------------------
// odo_result_if
// Output channel: position, heading and scaled origin distance.
// ----------------------------------------------------------------------------
interface odo_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic        [23:0] heading_out;
    logic        [31:0] travel_distance;

    modport source (output valid, output pos_x, output pos_y, output heading_out,
                    output travel_distance, input ready);
    modport sink   (input valid, input pos_x, input pos_y, input heading_out,
                    input travel_distance, output ready);
endinterface

>>> design/odo_regs.sv
// ----------------------------------------------------------------------------
// odo_regs
// APB-style configuration registers with zero-wait-state access.
// ----------------------------------------------------------------------------
module odo_regs (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    output odo_pkg::cfg_t      cfg
);

    odo_pkg::cfg_t cfg_reg;
    logic          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign cfg    = cfg_reg;

    // Write the addressed register, ignore addresses beyond the map
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dist_per_pulse  <= odo_pkg::DIST_PER_PULSE_RST;
            cfg_reg.angle_per_pulse <= odo_pkg::ANGLE_PER_PULSE_RST;
            cfg_reg.distance_scale  <= odo_pkg::DISTANCE_SCALE_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                odo_pkg::REG_DIST_PER_PULSE:  cfg_reg.dist_per_pulse  <= pwdata[23:0];
                odo_pkg::REG_ANGLE_PER_PULSE: cfg_reg.angle_per_pulse <= pwdata[23:0];
                odo_pkg::REG_DISTANCE_SCALE:  cfg_reg.distance_scale  <= pwdata[17:0];
                default: ;
            endcase
        end
    end

    // Return the addressed register
    always_comb
    begin
        case (paddr[3:2])
            odo_pkg::REG_DIST_PER_PULSE:  prdata = {8'd0, cfg_reg.dist_per_pulse};
            odo_pkg::REG_ANGLE_PER_PULSE: prdata = {8'd0, cfg_reg.angle_per_pulse};
            odo_pkg::REG_DISTANCE_SCALE:  prdata = {14'd0, cfg_reg.distance_scale};
            default:                      prdata = 32'd0;
        endcase
    end

endmodule

>>> design/odo_ctrl.sv
// ----------------------------------------------------------------------------
// odo_ctrl
// Sequencer: steps the datapath through heading, CORDIC, position update,
// square root and scaling for one sample.
// ----------------------------------------------------------------------------
module odo_ctrl #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              accept,
    input  odo_pkg::status_t  status,
    output logic              ready,
    output odo_pkg::cmd_t     cmd
);

    typedef enum logic [4:0] {
        S_IDLE, S_HEAD, S_SUM, S_INIT, S_ROT, S_FIX, S_MXL, S_MXH, S_MYL,
        S_MYH, S_SQX, S_SQY, S_SQY2, S_SQI, S_ROOT, S_SCALE, S_OUT
    } state_t;

    localparam logic [4:0] ROT_LAST  = 5'(CORDIC_STEPS - 1);
    localparam logic [4:0] ROOT_LAST = 5'd31;

    state_t        state_reg;
    logic          ready_reg;
    odo_pkg::cmd_t cmd_reg;

    assign ready = ready_reg;
    assign cmd   = cmd_reg;

    // Hold state and registered command
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            ready_reg   <= 1'b1;
            cmd_reg.op  <= odo_pkg::OP_NONE;
            cmd_reg.idx <= 5'd0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg  <= S_HEAD;
                        ready_reg  <= 1'b0;
                        cmd_reg.op <= odo_pkg::OP_HEAD;
                    end
                end
                S_HEAD:  begin state_reg <= S_SUM;  cmd_reg.op <= odo_pkg::OP_SUM;  end
                S_SUM:   begin state_reg <= S_INIT; cmd_reg.op <= odo_pkg::OP_INIT; end
                S_INIT:
                begin
                    state_reg   <= S_ROT;
                    cmd_reg.op  <= odo_pkg::OP_ROT;
                    cmd_reg.idx <= 5'd0;
                end
                S_ROT:
                begin
                    if (cmd_reg.idx == ROT_LAST)
                    begin
                        state_reg  <= S_FIX;
                        cmd_reg.op <= odo_pkg::OP_FIX;
                    end
                    else
                    begin
                        cmd_reg.idx <= cmd_reg.idx + 5'd1;
                    end
                end
                S_FIX:  begin state_reg <= S_MXL;  cmd_reg.op <= odo_pkg::OP_MXL;  end
                S_MXL:  begin state_reg <= S_MXH;  cmd_reg.op <= odo_pkg::OP_MXH;  end
                S_MXH:  begin state_reg <= S_MYL;  cmd_reg.op <= odo_pkg::OP_MYL;  end
                S_MYL:  begin state_reg <= S_MYH;  cmd_reg.op <= odo_pkg::OP_MYH;  end
                S_MYH:  begin state_reg <= S_SQX;  cmd_reg.op <= odo_pkg::OP_SQX;  end
                S_SQX:  begin state_reg <= S_SQY;  cmd_reg.op <= odo_pkg::OP_SQY;  end
                S_SQY:  begin state_reg <= S_SQY2; cmd_reg.op <= odo_pkg::OP_SQY2; end
                S_SQY2: begin state_reg <= S_SQI;  cmd_reg.op <= odo_pkg::OP_SQI;  end
                S_SQI:
                begin
                    state_reg   <= S_ROOT;
                    cmd_reg.op  <= odo_pkg::OP_ROOT;
                    cmd_reg.idx <= 5'd0;
                end
                S_ROOT:
                begin
                    if (cmd_reg.idx == ROOT_LAST)
                    begin
                        state_reg  <= S_SCALE;
                        cmd_reg.op <= odo_pkg::OP_SCALE;
                    end
                    else
                    begin
                        cmd_reg.idx <= cmd_reg.idx + 5'd1;
                    end
                end
                S_SCALE: begin state_reg <= S_OUT; cmd_reg.op <= odo_pkg::OP_OUT; end
                S_OUT:
                begin
                    // wait for the output register to free up
                    if (!status.out_busy)
                    begin
                        state_reg  <= S_IDLE;
                        ready_reg  <= 1'b1;
                        cmd_reg.op <= odo_pkg::OP_NONE;
                    end
                end
                default:
                begin
                    state_reg  <= S_IDLE;
                    ready_reg  <= 1'b1;
                    cmd_reg.op <= odo_pkg::OP_NONE;
                end
            endcase
        end
    end

endmodule

>>> design/odo_dp.sv
// ----------------------------------------------------------------------------
// odo_dp
// Datapath: shared multiplier, CORDIC rotator, saturating accumulators,
// bit-pair square root and the output register.
// ----------------------------------------------------------------------------
module odo_dp (
    input  logic               clk,
    input  logic               rst_n,
    input  odo_pkg::cfg_t      cfg,
    input  odo_pkg::cmd_t      cmd,
    input  logic               accept,
    input  logic [15:0]        pulses_left,
    input  logic [15:0]        pulses_right,
    input  logic               out_ready,
    output odo_pkg::status_t   status,
    output logic               out_valid,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic [23:0]        heading_out,
    output logic [31:0]        travel_distance
);

    logic [15:0]        pl_reg, pr_reg;
    logic [23:0]        heading_reg;
    logic signed [31:0] x_acc_reg, y_acc_reg;
    logic [31:0]        mean_reg;
    logic signed [33:0] cx_reg, cy_reg, cz_reg;
    logic               neg_reg;
    logic signed [32:0] c_reg, s_reg;
    logic signed [65:0] prod_reg, lo_reg;
    logic signed [35:0] d_reg;
    logic [63:0]        sq_reg, rem_reg, res_reg;
    logic               out_valid_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg;
    logic [23:0]        heading_out_reg;
    logic [31:0]        dist_reg;

    logic signed [32:0] mul_a, mul_b;
    logic               out_load;
    logic signed [33:0] z_init, xs, ys, atan_v;
    logic signed [65:0] d_sum;
    logic [63:0]        bitv, trial;
    logic [49:0]        dist_round;

    assign status.out_busy = out_valid_reg && !out_ready;
    assign out_load        = (cmd.op == odo_pkg::OP_OUT) && !status.out_busy;

    assign out_valid       = out_valid_reg;
    assign pos_x           = pos_x_reg;
    assign pos_y           = pos_y_reg;
    assign heading_out     = heading_out_reg;
    assign travel_distance = dist_reg;

    // Select multiplier operands for the current step
    always_comb
    begin
        mul_a = 33'sd0;
        mul_b = 33'sd0;
        case (cmd.op)
            odo_pkg::OP_HEAD:
            begin
                mul_a = $signed({17'd0, pr_reg}) - $signed({17'd0, pl_reg});
                mul_b = $signed({9'd0, cfg.angle_per_pulse});
            end
            odo_pkg::OP_SUM:
            begin
                mul_a = $signed({17'd0, pl_reg}) + $signed({17'd0, pr_reg});
                mul_b = $signed({9'd0, cfg.dist_per_pulse});
            end
            odo_pkg::OP_MXL:  begin mul_a = $signed({17'd0, mean_reg[15:0]});  mul_b = c_reg; end
            odo_pkg::OP_MXH:  begin mul_a = $signed({17'd0, mean_reg[31:16]}); mul_b = c_reg; end
            odo_pkg::OP_MYL:  begin mul_a = $signed({17'd0, mean_reg[15:0]});  mul_b = s_reg; end
            odo_pkg::OP_MYH:  begin mul_a = $signed({17'd0, mean_reg[31:16]}); mul_b = s_reg; end
            odo_pkg::OP_SQX:
            begin
                mul_a = $signed({x_acc_reg[31], x_acc_reg});
                mul_b = $signed({x_acc_reg[31], x_acc_reg});
            end
            odo_pkg::OP_SQY2:
            begin
                mul_a = $signed({y_acc_reg[31], y_acc_reg});
                mul_b = $signed({y_acc_reg[31], y_acc_reg});
            end
            odo_pkg::OP_SCALE, odo_pkg::OP_OUT:
            begin
                mul_a = $signed({1'b0, res_reg[31:0]});
                mul_b = $signed({15'd0, cfg.distance_scale});
            end
            default: ;
        endcase
    end

    // Heading as a signed angle in 2^-32 turn units; OP_INIT folds it into [-1/4, 1/4] turn
    always_comb
    begin
        z_init = $signed({{2{heading_reg[23]}}, heading_reg, 8'd0});
    end

    // One CORDIC micro-rotation, one square-root digit, rounding adders
    always_comb
    begin
        xs         = cx_reg >>> cmd.idx;
        ys         = cy_reg >>> cmd.idx;
        atan_v     = odo_pkg::atan_turn(cmd.idx);
        d_sum      = lo_reg + (prod_reg <<< 16) + 66'sd536870912;
        bitv       = 64'd1 << (6'd62 - {cmd.idx, 1'b0});
        trial      = res_reg + bitv;
        dist_round = prod_reg[49:0] + 50'd32768;
    end

    // Capture the accepted sample
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            pl_reg <= pulses_left;
            pr_reg <= pulses_right;
        end
    end

    // Multiplier product register
    always_ff @(posedge clk)
    begin
        prod_reg <= mul_a * mul_b;
    end

    // Advance the datapath state for each step
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heading_reg <= 24'd0;
            x_acc_reg   <= 32'sd0;
            y_acc_reg   <= 32'sd0;
        end
        else
        begin
            case (cmd.op)
                odo_pkg::OP_SUM: heading_reg <= heading_reg + prod_reg[23:0];
                odo_pkg::OP_MYH: x_acc_reg <= odo_pkg::sat32(37'(x_acc_reg) + 37'(d_reg));
                odo_pkg::OP_SQY: y_acc_reg <= odo_pkg::sat32(37'(y_acc_reg) + 37'(d_reg));
                default: ;
            endcase
        end
    end

    // Working registers of the per-sample computation
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            odo_pkg::OP_INIT:
            begin
                mean_reg <= 32'((prod_reg[40:0] + 41'd256) >> 9);
                cx_reg   <= odo_pkg::CORDIC_GAIN;
                cy_reg   <= 34'sd0;
                if (z_init > 34'sd1073741824)
                begin
                    cz_reg  <= z_init - 34'sd2147483648;
                    neg_reg <= 1'b1;
                end
                else if (z_init < -34'sd1073741824)
                begin
                    cz_reg  <= z_init + 34'sd2147483648;
                    neg_reg <= 1'b1;
                end
                else
                begin
                    cz_reg  <= z_init;
                    neg_reg <= 1'b0;
                end
            end
            odo_pkg::OP_ROT:
            begin
                if (cz_reg >= 34'sd0)
                begin
                    cx_reg <= cx_reg - ys;
                    cy_reg <= cy_reg + xs;
                    cz_reg <= cz_reg - atan_v;
                end
                else
                begin
                    cx_reg <= cx_reg + ys;
                    cy_reg <= cy_reg - xs;
                    cz_reg <= cz_reg + atan_v;
                end
            end
            odo_pkg::OP_FIX:
            begin
                c_reg <= neg_reg ? 33'(-cx_reg) : 33'(cx_reg);
                s_reg <= neg_reg ? 33'(-cy_reg) : 33'(cy_reg);
            end
            odo_pkg::OP_MXH: lo_reg <= prod_reg;
            odo_pkg::OP_MYL: d_reg <= d_sum[65:30];
            odo_pkg::OP_MYH: lo_reg <= prod_reg;
            odo_pkg::OP_SQX: d_reg <= d_sum[65:30];
            odo_pkg::OP_SQY: sq_reg <= prod_reg[63:0];
            odo_pkg::OP_SQI:
            begin
                rem_reg <= sq_reg + prod_reg[63:0];
                res_reg <= 64'd0;
            end
            odo_pkg::OP_ROOT:
            begin
                if (rem_reg >= trial)
                begin
                    rem_reg <= rem_reg - trial;
                    res_reg <= (res_reg >> 1) + bitv;
                end
                else
                begin
                    res_reg <= res_reg >> 1;
                end
            end
            default: ;
        endcase
    end

    // Output register: load when free, drop valid once taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            pos_x_reg       <= x_acc_reg;
            pos_y_reg       <= y_acc_reg;
            heading_out_reg <= heading_reg;
            dist_reg        <= (|dist_round[49:48]) ? 32'hFFFFFFFF : dist_round[47:16];
        end
    end

endmodule

>>> design/differential_drive_odometry_unit.sv
// ----------------------------------------------------------------------------
// differential_drive_odometry_unit
// Dead-reckoning odometry for a differential-drive platform.
// ----------------------------------------------------------------------------
// Usage:
//   sample carries the left and right encoder pulse counts of one period;
//   a transaction completes when valid and ready are both high.
//   result carries x, y (Q16.16), the 24-bit heading and the scaled
//   distance from the origin, one transaction per sample.
//   The APB port sets distance per pulse, angle per pulse and the distance
//   scale; write it only while no sample is in flight.
// Timing:
//   An accepted sample goes through the heading and distance products, the
//   one-per-cycle CORDIC rotations, the position update and squares on the
//   shared multiplier, the 32 one-digit square-root steps and the scaling.
//   One sample is processed at a time; the next is taken from the cycle
//   after the result is loaded into the output register.
//   If the receiver stalls, the finished result holds in the output register
//   and the block takes one more sample, then waits before loading its result.
//   Reset clears heading and position, loads the register defaults and
//   leaves the block ready for a sample.
// ----------------------------------------------------------------------------
module differential_drive_odometry_unit #(
    parameter int CORDIC_STEPS = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [3:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    odo_sample_if.sink    sample,
    odo_result_if.source  result
);

    odo_pkg::cfg_t    cfg;
    odo_pkg::cmd_t    cmd;
    odo_pkg::status_t status;
    logic             in_ready;
    logic             accept;

    assign sample.ready = in_ready;
    assign accept       = sample.valid && in_ready;

    odo_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    odo_ctrl #(
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .status (status),
        .ready  (in_ready),
        .cmd    (cmd)
    );

    odo_dp u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg),
        .cmd             (cmd),
        .accept          (accept),
        .pulses_left     (sample.pulses_left),
        .pulses_right    (sample.pulses_right),
        .out_ready       (result.ready),
        .status          (status),
        .out_valid       (result.valid),
        .pos_x           (result.pos_x),
        .pos_y           (result.pos_y),
        .heading_out     (result.heading_out),
        .travel_distance (result.travel_distance)
    );

endmodule
